// File: rtl/sm3_pkg.sv
package sm3_pkg;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_FINAL  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;
    localparam logic [1:0] REQ_LOAD   = 2'd3;

    localparam logic [0:0] CFG_RESUME_ENABLE = 1'd0;
    localparam logic [0:0] CFG_PRIOR_LENGTH  = 1'd1;

    localparam int CFG_DATA_W = 61;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic [2:0]  word_index;
        logic [31:0] start_word;
    } t_req;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_upper_mid;
        logic [63:0] digest_lower_mid;
        logic [63:0] digest_low;
    } t_digest;

    function automatic t_word iv_word(input logic [2:0] idx);
        t_word r;
        case (idx)
            3'd0: r = 32'h7380166f;
            3'd1: r = 32'h4914b2b9;
            3'd2: r = 32'h172442d7;
            3'd3: r = 32'hda8a0600;
            3'd4: r = 32'ha96f30bc;
            3'd5: r = 32'h163138aa;
            3'd6: r = 32'he38dee4d;
            default: r = 32'hb0fb0e4e;
        endcase
        return r;
    endfunction

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// File: rtl/sm3_req_if.sv
interface sm3_req_if;
    import sm3_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sm3_dig_if.sv
interface sm3_dig_if;
    import sm3_pkg::*;
    logic valid;
    logic ready;
    t_digest payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sm3_hash_engine_core.sv
// SM3 hash engine. Requests arrive one item at a time: a message byte, a final
// byte, a finish with no byte, or a load of one of eight resume start words.
// Bytes are packed straight into a 16-word message window. A plain byte or a
// start word load leaves the engine idle, so the next item can follow at once. The
// byte that fills the 64-byte block starts one shared round unit: it loads the
// working words, runs 64 rounds at one per cycle (the window slides to
// expand the message schedule), and folds the result into the chaining value.
// The input is not ready while this runs. A final byte or a finish then
// writes the padding one byte per cycle, from the 0x80 mark to byte 63, and
// compresses. If the mark lands past byte 55 there is no room for the
// length, so a second block of 64 pad bytes and its compression follows.
// A final byte that fills a block first compresses that block and then pads
// a fresh one. The digest item waits in an output register until taken, and
// the input is not ready until it is taken.
// Resume mode (register 0) is sampled at the start of each message and loads
// the chaining value from the start words. Register 1 holds the prior message
// byte length, whose padded length is added to the bit length in resume
// mode. Configure only while idle.
module sm3_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sm3_req_if.sink     req,
    sm3_dig_if.source   dig,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [sm3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sm3_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;   // write mark/zero/length bytes
    localparam logic [2:0] ST_LOAD  = 3'd2;   // load working words
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;

    logic [2:0]  r_state;
    logic        r_resume_en;
    logic [60:0] r_prior;
    t_word       r_cv [8];
    t_word       r_resume [8];
    t_word       r_w [16];
    t_word       r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [63:0] r_count;
    logic [63:0] r_bits;
    logic [5:0]  r_ppos;        // next pad byte position
    logic        r_mark_done;   // 0x80 already written
    logic        r_len_here;    // length goes at the end of this block
    logic        r_finishing;
    logic [6:0]  r_round;
    logic        r_in_msg;
    logic        r_mode;
    t_digest     r_dig;
    logic        r_dig_valid;

    logic acc;
    assign req.ready = i_rst_n && (r_state == ST_IDLE) && !r_dig_valid;
    assign acc = req.valid && req.ready;
    assign dig.valid = r_dig_valid;
    assign dig.payload = r_dig;

    // round datapath
    logic        lo;
    t_word       tconst, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
    always_comb begin
        lo = (r_round < 7'd16);
        tconst = rotl(lo ? T_LOW : T_HIGH, r_round[4:0]);
        a12 = rotl(r_a, 5'd12);
        ss1 = rotl(a12 + r_e + tconst, 5'd7);
        ss2 = ss1 ^ a12;
        ff = lo ? (r_a ^ r_b ^ r_c) : ((r_a & r_b) | (r_a & r_c) | (r_b & r_c));
        gg = lo ? (r_e ^ r_f ^ r_g) : ((r_e & r_f) | (~r_e & r_g));
        tt1 = ff + r_d + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_h + ss1 + r_w[0];
        wnew = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15)) ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    // byte count and bit length for the item on the input
    logic        has_byte, use_resume;
    logic [63:0] base_cnt, next_cnt, prior_sum, pad_prior, units;
    always_comb begin
        has_byte = (req.payload.req_type == REQ_BYTE) || (req.payload.req_type == REQ_FINAL);
        base_cnt = r_in_msg ? r_count : 64'd0;
        next_cnt = base_cnt + {63'd0, has_byte};
        use_resume = r_in_msg ? r_mode : r_resume_en;
        prior_sum = {3'd0, r_prior} + 64'd72;
        pad_prior = {prior_sum[63:6], 6'd0};
        units = next_cnt + (use_resume ? pad_prior : 64'd0);
    end

    logic [7:0] pad_byte;
    always_comb begin
        if (!r_mark_done)
            pad_byte = PAD_BYTE;
        else if (r_ppos >= 6'd56 && r_len_here)
            pad_byte = r_bits[{~r_ppos[2:0], 3'b000} +: 8];
        else
            pad_byte = 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_resume_en <= 1'b0;
            r_prior <= '0;
            r_count <= '0;
            r_bits <= '0;
            r_ppos <= '0;
            r_in_msg <= 1'b0;
            r_mode <= 1'b0;
            r_dig <= '0;
            r_dig_valid <= 1'b0;
            r_round <= '0;
            r_finishing <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_here <= 1'b0;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0;
            r_e <= '0; r_f <= '0; r_g <= '0; r_h <= '0;
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= iv_word(3'(i));
                r_resume[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RESUME_ENABLE) r_resume_en <= i_cfg_data[0];
                else r_prior <= i_cfg_data;
            end
            if (dig.valid && dig.ready) r_dig_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (req.payload.req_type == REQ_LOAD) begin
                            r_resume[req.payload.word_index] <= req.payload.start_word;
                        end else begin
                            // first item of a message: latch mode, load chaining value
                            if (!r_in_msg) begin
                                r_mode <= r_resume_en;
                                for (int i = 0; i < 8; i++)
                                    r_cv[i] <= r_resume_en ? r_resume[i] : iv_word(3'(i));
                            end
                            r_in_msg <= 1'b1;
                            r_count <= next_cnt;
                            if (has_byte)
                                r_w[base_cnt[5:2]][{~base_cnt[1:0], 3'b000} +: 8]
                                    <= req.payload.data_byte;
                            if (req.payload.req_type != REQ_BYTE) begin
                                r_finishing <= 1'b1;
                                r_mark_done <= 1'b0;
                                r_bits <= {units[60:0], 3'b000};
                                r_ppos <= next_cnt[5:0];
                            end else begin
                                r_finishing <= 1'b0;
                            end
                            // a full block compresses before any padding
                            if (has_byte && next_cnt[5:0] == 6'd0)
                                r_state <= ST_LOAD;
                            else if (req.payload.req_type != REQ_BYTE)
                                r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_w[r_ppos[5:2]][{~r_ppos[1:0], 3'b000} +: 8] <= pad_byte;
                    if (!r_mark_done) begin
                        r_mark_done <= 1'b1;
                        // a mark past byte 55 pushes the length to the next block
                        r_len_here <= (r_ppos <= 6'd55);
                    end
                    r_ppos <= r_ppos + 6'd1;
                    if (r_ppos == 6'd63) r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_a <= r_cv[0]; r_b <= r_cv[1]; r_c <= r_cv[2]; r_d <= r_cv[3];
                    r_e <= r_cv[4]; r_f <= r_cv[5]; r_g <= r_cv[6]; r_h <= r_cv[7];
                    r_round <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_d <= r_c; r_c <= rotl(r_b, 5'd9); r_b <= r_a; r_a <= tt1;
                    r_h <= r_g; r_g <= rotl(r_f, 5'd19); r_f <= r_e; r_e <= perm0(tt2);
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wnew;
                    if (r_round == 7'd63) begin
                        r_round <= '0;
                        r_state <= ST_FOLD;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                ST_FOLD: begin
                    r_cv[0] <= r_cv[0] ^ r_a; r_cv[1] <= r_cv[1] ^ r_b;
                    r_cv[2] <= r_cv[2] ^ r_c; r_cv[3] <= r_cv[3] ^ r_d;
                    r_cv[4] <= r_cv[4] ^ r_e; r_cv[5] <= r_cv[5] ^ r_f;
                    r_cv[6] <= r_cv[6] ^ r_g; r_cv[7] <= r_cv[7] ^ r_h;
                    if (!r_finishing) begin
                        r_state <= ST_IDLE;
                    end else if (r_mark_done && r_len_here) begin
                        // length went into this block: emit the digest
                        r_dig <= {r_cv[0] ^ r_a, r_cv[1] ^ r_b, r_cv[2] ^ r_c, r_cv[3] ^ r_d,
                                  r_cv[4] ^ r_e, r_cv[5] ^ r_f, r_cv[6] ^ r_g, r_cv[7] ^ r_h};
                        r_dig_valid <= 1'b1;
                        r_in_msg <= 1'b0;
                        r_count <= '0;
                        r_finishing <= 1'b0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_ppos <= '0;
                        r_len_here <= 1'b1;
                        r_state <= ST_PAD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_dig_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dig_valid && !dig.ready |=> r_dig_valid && $stable(r_dig))
        else $error("digest dropped or changed");
    a_no_acc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dig_valid |-> !req.ready) else $error("accept while digest waits");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round < 7'd64) else $error("round index out of range");
endmodule
